/* design/positional_list_store_defines.svh */
// Assertion macros shared by the positional list store RTL.
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define PLS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// When the trigger holds, the check must hold in the next cycle.
`define PLS_ASSERT_NEXT(lbl, trig, chk, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (chk)) \
    else $error(msg);

`endif

/* design/pls_pkg.sv */
// Shared widths, request and status codes, and the cell command type.
`default_nettype none

package pls_pkg;

  localparam int TypeW       = 2;
  localparam int PosW        = 5;
  localparam int ValW        = 32;
  localparam int StatW       = 2;
  localparam int CountW      = 5;
  localparam int DefCapacity = 16;

  localparam logic [TypeW-1:0] REQ_INSERT = 2'd0;
  localparam logic [TypeW-1:0] REQ_DELETE = 2'd1;
  localparam logic [TypeW-1:0] REQ_READ   = 2'd2;

  localparam logic [StatW-1:0] ST_DONE  = 2'd0;
  localparam logic [StatW-1:0] ST_RANGE = 2'd1;
  localparam logic [StatW-1:0] ST_FULL  = 2'd2;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    logic                   ins;
    logic                   del;
    logic [PosW-1:0]        slot;
    logic signed [ValW-1:0] value;
  } cell_cmd_t;

endpackage

`default_nettype wire

/* design/pls_cell.sv */
// One storage cell of the list chain; shifts with its neighbors on insert and delete.
`default_nettype none

module pls_cell import pls_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire                   clk_i,
  input  wire cell_cmd_t        cmd_i,
  input  wire signed [ValW-1:0] left_i,
  input  wire signed [ValW-1:0] right_i,
  output logic signed [ValW-1:0] val_o
);

  localparam logic [31:0] IdxL = 32'(IDX);

  logic [31:0]            slot_ext;
  logic signed [ValW-1:0] val_d;
  logic signed [ValW-1:0] val_q;

  assign slot_ext = 32'(cmd_i.slot);

  always_comb begin
    val_d = val_q;
    if (cmd_i.ins) begin
      if (IdxL == slot_ext) begin
        val_d = cmd_i.value;
      end else if (IdxL > slot_ext) begin
        val_d = left_i;
      end
    end else if (cmd_i.del) begin
      if (IdxL >= slot_ext) begin
        val_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

`default_nettype wire

/* design/positional_list_store.sv */
// Positional list store: an ordered list of signed values held in a chain of cells.
// A result is registered and becomes valid in the cycle after its item is accepted.
// One item per cycle while the input is not stalled; every cell shifts in parallel on insert or delete.
// The input stalls only while a finished result waits on a stalled output.
// Reset clears the element count and the output valid; cell contents are undefined.
`default_nettype none
`include "positional_list_store_defines.svh"

module positional_list_store import pls_pkg::*; #(
  parameter int CAPACITY = DefCapacity
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  wire  [TypeW-1:0]       req_type_i,
  input  wire  [PosW-1:0]        position_i,
  input  wire  signed [ValW-1:0] value_i,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output logic [StatW-1:0]       status_o,
  output logic signed [ValW-1:0] read_value_o,
  output logic [CountW-1:0]      element_count_o
);

  // The count must hold CAPACITY itself. Only the first 31 cells can ever be
  // named by a position, so the read selection spans at most those.
  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int CmpW  = ((CntW > PosW) ? CntW : PosW) + 1;
  localparam int ReadN = (CAPACITY < 31) ? CAPACITY : 31;

  logic                   in_acc;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [CmpW-1:0]        pos_ext, cnt_ext;
  logic                   pos_nz, ins_range, acc_range, full;
  logic                   ins_ok, del_ok, rd_ok;
  logic [StatW-1:0]       status_d;
  logic signed [ValW-1:0] rd_d;
  cell_cmd_t              cmd;
  logic signed [ValW-1:0] cell_val [CAPACITY];

  logic                   out_valid_q;
  logic [StatW-1:0]       status_q;
  logic signed [ValW-1:0] read_value_q;
  logic [CountW-1:0]      count_q;

  // A new item is taken unless the held result is still stalled.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // Range checks on 1-based positions against the current element count.
  assign pos_ext   = CmpW'(position_i);
  assign cnt_ext   = CmpW'(cnt_q);
  assign pos_nz    = (position_i != '0);
  assign ins_range = pos_nz && (pos_ext <= cnt_ext + CmpW'(1));
  assign acc_range = pos_nz && (pos_ext <= cnt_ext);
  assign full      = (cnt_q == CntW'(CAPACITY));

  assign ins_ok = in_acc && (req_type_i == REQ_INSERT) && ins_range && !full;
  assign del_ok = in_acc && (req_type_i == REQ_DELETE) && acc_range;
  assign rd_ok  = (req_type_i == REQ_READ) && acc_range;

  // The command reaches every cell; the slot is the 0-based position.
  assign cmd.ins   = ins_ok;
  assign cmd.del   = del_ok;
  assign cmd.slot  = position_i - PosW'(1);
  assign cmd.value = value_i;

  always_comb begin
    status_d = ST_RANGE;
    case (req_type_i)
      REQ_INSERT: begin
        if (ins_range) begin
          status_d = full ? ST_FULL : ST_DONE;
        end
      end
      REQ_DELETE, REQ_READ: begin
        if (acc_range) begin
          status_d = ST_DONE;
        end
      end
      default: status_d = ST_RANGE;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ins_ok) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (del_ok) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  // The read picks one of the nameable cells; a failed read answers zero.
  always_comb begin
    rd_d = '0;
    for (int k = 0; k < ReadN; k++) begin
      rd_d = rd_d | ((rd_ok && (cmd.slot == PosW'(k))) ? cell_val[k] : '0);
    end
  end

  // The chain: each cell sees its left neighbor for an insert shift and its
  // right neighbor for a delete shift. The end cells take their own value
  // where no neighbor exists; those inputs never reach a held element.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [ValW-1:0] left_val, right_val;
    if (g == 0) begin : g_first
      assign left_val = cell_val[g];
    end else begin : g_left
      assign left_val = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_val = cell_val[g];
    end else begin : g_right
      assign right_val = cell_val[g+1];
    end
    pls_cell #(
      .IDX(g)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .left_i (left_val),
      .right_i(right_val),
      .val_o  (cell_val[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload; the reported count is the count after the request.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      status_q     <= status_d;
      read_value_q <= rd_d;
      count_q      <= CountW'(cnt_d);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign read_value_o    = read_value_q;
  assign element_count_o = count_q;

  `PLS_ASSERT_ALWAYS(a_count_bound, cnt_q <= CntW'(CAPACITY), "element count beyond capacity")
  `PLS_ASSERT_NEXT(a_ins_count, ins_ok, cnt_q == CntW'($past(cnt_q) + CntW'(1)), "insert did not grow count")
  `PLS_ASSERT_NEXT(a_del_count, del_ok, cnt_q == CntW'($past(cnt_q) - CntW'(1)), "delete did not shrink count")
  `PLS_ASSERT_ALWAYS(a_full_status, !(in_acc && status_d == ST_FULL) || full, "full status while not full")
  `PLS_ASSERT_NEXT(a_result_valid, in_acc, out_valid_q, "accepted item left no result")

endmodule

`default_nettype wire

/* tb/positional_list_store_tb.sv */
// Self-checking testbench for the positional list store, with its own model of the list.
`timescale 1ns / 100ps

module positional_list_store_tb import pls_pkg::*; ();

  // The request code that the block leaves unused; it must answer with a range error.
  localparam logic [TypeW-1:0] REQ_UNUSED = 2'd3;
  localparam int Capacity      = DefCapacity;
  // Longest correct quiet stretch is the long receiver hold plus one gap.
  localparam int HoldCycles    = 150;
  localparam int WatchdogLimit = 2000;

  typedef struct packed {
    logic [StatW-1:0]       status;
    logic signed [ValW-1:0] read_value;
    logic [CountW-1:0]      count;
  } list_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [TypeW-1:0]       req_type;
  logic [PosW-1:0]        position;
  logic signed [ValW-1:0] value;
  logic                   out_valid;
  logic                   out_stall;
  logic [StatW-1:0]       status;
  logic signed [ValW-1:0] read_value;
  logic [CountW-1:0]      element_count;

  positional_list_store #(.CAPACITY(Capacity)) uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .req_type_i     (req_type),
    .position_i     (position),
    .value_i        (value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .read_value_o   (read_value),
    .element_count_o(element_count)
  );

  // Model of the list: the elements in list order and how many are held.
  logic signed [ValW-1:0] list_cells [Capacity];
  int                     list_len;

  // Results the block owes, oldest first.
  list_result_t expected_results [$];

  int  mismatches;
  int  quiet_cycles;
  bit  tx_burst;      // Sender offers items without gaps while set.
  bit  rx_burst;      // Receiver takes results without stalling while set.
  bit  hold_request;  // Asks the receiver for one long hold.

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Applies one request to the model and returns the result it must produce.
  function automatic list_result_t apply_request(input logic [TypeW-1:0] kind,
                                                 input logic [PosW-1:0] pos,
                                                 input logic signed [ValW-1:0] val);
    list_result_t res;
    int           p;
    int           i;
    p = int'(pos);
    res.status = ST_RANGE;
    res.read_value = '0;
    case (kind)
      REQ_INSERT: begin
        // The position check comes before the full check.
        if (p >= 1 && p <= list_len + 1) begin
          if (list_len >= Capacity) begin
            res.status = ST_FULL;
          end else begin
            for (i = list_len; i > p - 1; i--) list_cells[i] = list_cells[i - 1];
            list_cells[p - 1] = val;
            list_len++;
            res.status = ST_DONE;
          end
        end
      end
      REQ_DELETE: begin
        if (p >= 1 && p <= list_len) begin
          for (i = p - 1; i + 1 < list_len; i++) list_cells[i] = list_cells[i + 1];
          list_len--;
          res.status = ST_DONE;
        end
      end
      REQ_READ: begin
        if (p >= 1 && p <= list_len) begin
          res.read_value = list_cells[p - 1];
          res.status = ST_DONE;
        end
      end
      default: begin
      end
    endcase
    res.count = CountW'(list_len);
    return res;
  endfunction

  // Wait before one item or one result; zero while a burst is set, otherwise drawn at random.
  function automatic int idle_draw(input bit burst);
    if (burst) return 0;
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return $urandom_range(0, 2);
      default: return $urandom_range(0, 15);
    endcase
  endfunction

  function automatic logic signed [ValW-1:0] random_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Offers one item after a random gap and returns at the edge that accepts it.
  // Valid stays high after acceptance; the next call or a drain decides at the next
  // falling edge whether it stays high.
  task automatic send_item(input logic [TypeW-1:0] kind, input logic [PosW-1:0] pos,
                           input logic signed [ValW-1:0] val);
    int gap;
    gap = idle_draw(tx_burst);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    position <= pos;
    value    <= val;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(apply_request(kind, pos, val));
  endtask

  // Sender pauses until every result owed has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Every request on an empty store, including the unused code and bad inserts.
  task automatic test_empty_requests();
    send_item(REQ_READ,   5'd1,  32'sd7);
    send_item(REQ_DELETE, 5'd1,  32'sd7);
    send_item(REQ_READ,   5'd0,  '0);
    send_item(REQ_DELETE, 5'd31, '0);
    send_item(REQ_INSERT, 5'd0,  32'sh1234_5678);
    send_item(REQ_INSERT, 5'd2,  32'sh1234_5678);
    send_item(REQ_UNUSED, 5'd1,  -32'sd1);
    drain_results();
  endtask

  // Insert first, last and in the middle with extreme values, then read and delete at
  // the ends and just past them.
  task automatic test_edge_positions();
    send_item(REQ_INSERT, 5'd1,  32'sh7FFF_FFFF);
    send_item(REQ_INSERT, 5'd2,  32'sh8000_0000);
    send_item(REQ_INSERT, 5'd2,  '0);
    send_item(REQ_INSERT, 5'd1,  -32'sd1);
    send_item(REQ_READ,   5'd1,  '0);
    send_item(REQ_READ,   5'd2,  '0);
    send_item(REQ_READ,   5'd3,  '0);
    send_item(REQ_READ,   5'd4,  '0);
    send_item(REQ_READ,   5'd5,  '0);
    send_item(REQ_READ,   5'd0,  '0);
    send_item(REQ_DELETE, 5'd5,  '0);
    send_item(REQ_INSERT, 5'd6,  32'sh5555_5555);
    send_item(REQ_DELETE, 5'd4,  '0);
    send_item(REQ_DELETE, 5'd1,  '0);
    send_item(REQ_READ,   5'd1,  '0);
    send_item(REQ_UNUSED, 5'd31, 32'shAAAA_AAAA);
    send_item(REQ_DELETE, 5'd1,  '0);
    send_item(REQ_DELETE, 5'd1,  '0);
    drain_results();
  endtask

  // Fills the store to capacity, tries inserts with good and bad positions, then reads and deletes at the end.
  task automatic test_full_store();
    while (list_len < Capacity) send_item(REQ_INSERT,
                                          PosW'($urandom_range(1, list_len + 1)),
                                          random_value());
    send_item(REQ_INSERT, 5'd17, random_value());
    send_item(REQ_INSERT, 5'd1,  random_value());
    send_item(REQ_INSERT, 5'd18, random_value());
    send_item(REQ_READ,   5'd16, '0);
    send_item(REQ_READ,   5'd17, '0);
    send_item(REQ_DELETE, 5'd16, '0);
    drain_results();
  endtask

  // Mostly well-formed requests against the current length, the rest noise over the
  // whole field ranges. insert_pct steers whether the store fills or empties.
  task automatic test_random_traffic(input int n, input int insert_pct);
    int               k;
    int               r;
    logic [TypeW-1:0] kind;
    logic [PosW-1:0]  pos;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 88) begin
        r = $urandom_range(0, 99);
        if (r < insert_pct) kind = REQ_INSERT;
        else if (r < insert_pct + (100 - insert_pct) / 2) kind = REQ_DELETE;
        else kind = REQ_READ;
        if (kind == REQ_INSERT) pos = PosW'($urandom_range(1, list_len + 1));
        else pos = (list_len == 0) ? 5'd1 : PosW'($urandom_range(1, list_len));
      end else begin
        kind = TypeW'($urandom_range(0, 3));
        pos  = PosW'($urandom_range(0, 31));
      end
      send_item(kind, pos, random_value());
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering items,
  // so the output register fills and the input stalls.
  task automatic test_back_pressure();
    hold_request = 1'b1;
    tx_burst = 1'b1;
    test_random_traffic(40, 50);
    tx_burst = 1'b0;
    drain_results();
  endtask

  // Receiver: draws a stall before each result, or takes the long hold when asked.
  initial begin
    int gap;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        gap = HoldCycles;
      end else begin
        gap = idle_draw(rx_burst);
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Result checker and watchdog. Each accepted result is compared with the oldest
  // expectation; the watchdog ends the run when nothing moves for too long.
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", {30'b0, status}, '0);
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status)
            report_mismatch("status", 32'(status), 32'(want.status));
          if (read_value !== want.read_value)
            report_mismatch("read_value", read_value, want.read_value);
          if (element_count !== want.count)
            report_mismatch("element_count", 32'(element_count), 32'(want.count));
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    req_type     = REQ_INSERT;
    position     = '0;
    value        = '0;
    mismatches   = 0;
    quiet_cycles = 0;
    tx_burst     = 1'b0;
    rx_burst     = 1'b0;
    hold_request = 1'b0;
    list_len     = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_requests();
    test_edge_positions();
    test_full_store();
    test_back_pressure();
    test_random_traffic(350, 70);
    drain_results();
    test_random_traffic(350, 25);
    // A stretch with no idling on either side.
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    test_random_traffic(200, 45);
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    test_random_traffic(350, 45);

    drain_results();
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
